>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros. They expand to concurrent assertions in simulation
// and to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hdl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and codes of the countdown timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package ctt_pkg;

  // Default number of timer slots.
  localparam int SLOTS_DEF = 16;

  // Field widths.
  localparam int OpW    = 2;
  localparam int IdW    = 8;
  localparam int CountW = 24;
  localparam int EvW    = 3;
  localparam int SlotW  = 6;

  // Operation codes of an input item.
  localparam logic [OpW-1:0] OP_START = 2'd0;
  localparam logic [OpW-1:0] OP_STOP  = 2'd1;
  localparam logic [OpW-1:0] OP_TICK  = 2'd2;

  // Result codes.
  localparam logic [EvW-1:0] EV_STARTED   = 3'd0;
  localparam logic [EvW-1:0] EV_RESTARTED = 3'd1;
  localparam logic [EvW-1:0] EV_FULL      = 3'd2;
  localparam logic [EvW-1:0] EV_STOPPED   = 3'd3;
  localparam logic [EvW-1:0] EV_NOTFOUND  = 3'd4;
  localparam logic [EvW-1:0] EV_EXPIRED   = 3'd5;
  localparam logic [EvW-1:0] EV_IDLE      = 3'd6;

  // Contents of one slot apart from its active flag.
  typedef struct packed {
    logic [IdW-1:0]    owner;
    logic [CountW-1:0] remaining;
    logic [CountW-1:0] period;
  } slot_body_t;

  // Full slot record as it travels along the ring.
  typedef struct packed {
    logic       active;
    slot_body_t body;
  } slot_rec_t;

endpackage

`default_nettype wire

>>> hdl/ctt_in_if.sv
// ----------------------------------------------------------------------------
// ctt_in_if
// Input item channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctt_in_if;
  logic                           valid;
  logic                           ready;
  logic [ctt_pkg::OpW-1:0]        op;
  logic [ctt_pkg::IdW-1:0]        timer_id;
  logic [ctt_pkg::CountW-1:0]     delay;
  logic [ctt_pkg::CountW-1:0]     period;

  modport source (output valid, output op, output timer_id, output delay, output period,
                  input ready);
  modport sink (input valid, input op, input timer_id, input delay, input period,
                output ready);
endinterface

`default_nettype wire

>>> hdl/ctt_out_if.sv
// ----------------------------------------------------------------------------
// ctt_out_if
// Result item channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctt_out_if;
  logic                         valid;
  logic                         ready;
  logic [ctt_pkg::EvW-1:0]      event_res;
  logic [ctt_pkg::IdW-1:0]      timer_id_res;
  logic [ctt_pkg::SlotW-1:0]    slot;
  logic                         last;

  modport source (output valid, output event_res, output timer_id_res, output slot,
                  output last, input ready);
  modport sink (input valid, input event_res, input timer_id_res, input slot,
                input last, output ready);
endinterface

`default_nettype wire

>>> hdl/ctt_cell.sv
// ----------------------------------------------------------------------------
// ctt_cell
// One timer slot of the ring. On a shift it takes the record of its
// neighbor; otherwise it holds its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  ctt_pkg::slot_rec_t rec_in,
  output ctt_pkg::slot_rec_t rec_out
);

  logic                active_r;
  ctt_pkg::slot_body_t body_r;

  // The active flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (shift_en) begin
      active_r <= rec_in.active;
    end
  end

  // Owner and counts are only read while the slot is active.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      body_r <= rec_in.body;
    end
  end

  assign rec_out.active = active_r;
  assign rec_out.body   = body_r;

endmodule

`default_nettype wire

>>> hdl/countdown_timer_table_unit.sv
// ----------------------------------------------------------------------------
// countdown_timer_table_unit
// Table of countdown timer slots held in a ring of cells. Slot records
// rotate past a single head position where they are searched, loaded,
// stopped or counted down.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Item
//  in_ch     in         valid/ready    op, timer_id, delay, period
//  out_ch    out        valid/ready    event_res, timer_id_res, slot, last
//
// A start or stop keeps the input busy after it is accepted: one full
// rotation of the ring to search for the owner and a free slot, a second to
// write the chosen slot, and the finish state to load the result. The next
// item can be taken in the cycle after the finish state. A tick keeps the
// input busy for one rotation, a step per slot at the head, plus the finish state.
// The finish cycle, and a tick step whose expiry must replace a held one,
// wait while the output register still holds an unsent result.
// An item with an unused op is taken without leaving idle.
// Reset clears every active flag and returns the controller to idle at once.
//
`default_nettype none

`include "assert_macros.svh"

module countdown_timer_table_unit #(
  parameter int SLOTS = ctt_pkg::SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ctt_in_if.sink    in_ch,
  ctt_out_if.source out_ch
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_APPLY, S_TICK, S_FINISH} state_t;

  // Ring of slot cells; cell 0 is the head.
  ctt_pkg::slot_rec_t cell_out [SLOTS];
  ctt_pkg::slot_rec_t cell_in  [SLOTS];
  ctt_pkg::slot_rec_t head;
  ctt_pkg::slot_rec_t head_nxt;
  logic               step;

  assign head = cell_out[0];

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      if (g == SLOTS - 1) begin : g_tail
        assign cell_in[g] = head_nxt;
      end else begin : g_mid
        assign cell_in[g] = cell_out[g+1];
      end
      ctt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (step),
        .rec_in   (cell_in[g]),
        .rec_out  (cell_out[g])
      );
    end
  endgenerate

  // Controller registers.
  state_t                        state_r, state_nxt;
  logic [IW-1:0]                 cnt_r, cnt_nxt;
  logic [ctt_pkg::OpW-1:0]       op_r, op_nxt;
  logic [ctt_pkg::IdW-1:0]       id_r, id_nxt;
  logic [ctt_pkg::CountW-1:0]    load_r, load_nxt;
  logic [ctt_pkg::CountW-1:0]    period_r, period_nxt;
  logic                          hit_r, hit_nxt;
  logic [IW-1:0]                 hit_idx_r, hit_idx_nxt;
  logic                          free_r, free_nxt;
  logic [IW-1:0]                 free_idx_r, free_idx_nxt;
  logic                          pend_vld_r, pend_vld_nxt;
  logic [ctt_pkg::IdW-1:0]       pend_id_r, pend_id_nxt;
  logic [IW-1:0]                 pend_idx_r, pend_idx_nxt;

  // Output register.
  logic                          out_vld_r, out_vld_nxt;
  logic [ctt_pkg::EvW-1:0]       out_ev_r, out_ev_nxt;
  logic [ctt_pkg::IdW-1:0]       out_id_r, out_id_nxt;
  logic [ctt_pkg::SlotW-1:0]     out_slot_r, out_slot_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          out_free;
  logic                          tgt_vld;
  logic [IW-1:0]                 tgt_idx;
  logic                          expire;
  logic                          push;
  logic [ctt_pkg::CountW-1:0]    dec;
  logic [ctt_pkg::EvW-1:0]       fin_ev;
  logic [ctt_pkg::IdW-1:0]       fin_id;
  logic [ctt_pkg::SlotW-1:0]     fin_slot;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free    = !out_vld_r || out_ch.ready;

  // Slot the second pass writes, and the final result of the item.
  always_comb begin
    tgt_vld  = 1'b0;
    tgt_idx  = hit_idx_r;
    fin_ev   = ctt_pkg::EV_IDLE;
    fin_id   = id_r;
    fin_slot = '0;
    case (op_r)
      ctt_pkg::OP_START: begin
        tgt_vld = hit_r || free_r;
        tgt_idx = hit_r ? hit_idx_r : free_idx_r;
        if (hit_r) begin
          fin_ev   = ctt_pkg::EV_RESTARTED;
          fin_slot = ctt_pkg::SlotW'(hit_idx_r);
        end else if (free_r) begin
          fin_ev   = ctt_pkg::EV_STARTED;
          fin_slot = ctt_pkg::SlotW'(free_idx_r);
        end else begin
          fin_ev = ctt_pkg::EV_FULL;
        end
      end
      ctt_pkg::OP_STOP: begin
        tgt_vld = hit_r;
        if (hit_r) begin
          fin_ev   = ctt_pkg::EV_STOPPED;
          fin_slot = ctt_pkg::SlotW'(hit_idx_r);
        end else begin
          fin_ev = ctt_pkg::EV_NOTFOUND;
        end
      end
      default: begin
        // Tick: the last expiry found, or a single no-expiry result.
        if (pend_vld_r) begin
          fin_ev   = ctt_pkg::EV_EXPIRED;
          fin_id   = pend_id_r;
          fin_slot = ctt_pkg::SlotW'(pend_idx_r);
        end else begin
          fin_id = '0;
        end
      end
    endcase
  end

  // Countdown at the head during a tick.
  assign dec    = head.body.remaining - ctt_pkg::CountW'(1);
  assign expire = head.active && (head.body.remaining == ctt_pkg::CountW'(1));
  assign push   = expire && pend_vld_r;

  // Controller next-state logic.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    load_nxt     = load_r;
    period_nxt   = period_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    pend_idx_nxt = pend_idx_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_ev_nxt   = out_ev_r;
    out_id_nxt   = out_id_r;
    out_slot_nxt = out_slot_r;
    out_last_nxt = out_last_r;
    step         = 1'b0;
    head_nxt     = head;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt       = in_ch.op;
          id_nxt       = in_ch.timer_id;
          load_nxt     = (in_ch.delay == '0) ? ctt_pkg::CountW'(1) : in_ch.delay;
          period_nxt   = in_ch.period;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          pend_vld_nxt = 1'b0;
          cnt_nxt      = '0;
          case (in_ch.op) inside
            ctt_pkg::OP_START, ctt_pkg::OP_STOP: state_nxt = S_SEARCH;
            ctt_pkg::OP_TICK:                    state_nxt = S_TICK;
            default:                             state_nxt = S_IDLE;
          endcase
        end
      end

      // First rotation: find the owner's slot and the lowest free slot.
      S_SEARCH: begin
        step = 1'b1;
        if (!hit_r && head.active && (head.body.owner == id_r)) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cnt_r;
        end
        if (!free_r && !head.active) begin
          free_nxt     = 1'b1;
          free_idx_nxt = cnt_r;
        end
        if (cnt_r == LastIdx) begin
          cnt_nxt   = '0;
          state_nxt = S_APPLY;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end

      // Second rotation: write the chosen slot as it passes the head.
      S_APPLY: begin
        step = 1'b1;
        if (tgt_vld && (cnt_r == tgt_idx)) begin
          if (op_r == ctt_pkg::OP_START) begin
            head_nxt.active         = 1'b1;
            head_nxt.body.owner     = id_r;
            head_nxt.body.remaining = load_r;
            head_nxt.body.period    = period_r;
          end else begin
            head_nxt.active = 1'b0;
          end
        end
        if (cnt_r == LastIdx) begin
          cnt_nxt   = '0;
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end

      // Tick: count down each slot; an earlier expiry is sent when a newer
      // one replaces it, so the final one can carry the last flag.
      S_TICK: begin
        if (!(push && !out_free)) begin
          step = 1'b1;
          if (head.active) begin
            if (expire) begin
              head_nxt.body.remaining = head.body.period;
              head_nxt.active         = (head.body.period != '0);
              pend_vld_nxt            = 1'b1;
              pend_id_nxt             = head.body.owner;
              pend_idx_nxt            = cnt_r;
            end else begin
              head_nxt.body.remaining = dec;
            end
          end
          if (push) begin
            out_vld_nxt  = 1'b1;
            out_ev_nxt   = ctt_pkg::EV_EXPIRED;
            out_id_nxt   = pend_id_r;
            out_slot_nxt = ctt_pkg::SlotW'(pend_idx_r);
            out_last_nxt = 1'b0;
          end
          if (cnt_r == LastIdx) begin
            cnt_nxt   = '0;
            state_nxt = S_FINISH;
          end else begin
            cnt_nxt = cnt_r + IW'(1);
          end
        end
      end

      // Issue the final result of the item.
      S_FINISH: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_ev_nxt   = fin_ev;
          out_id_nxt   = fin_id;
          out_slot_nxt = fin_slot;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      hit_r      <= hit_nxt;
      free_r     <= free_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    load_r     <= load_nxt;
    period_r   <= period_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_ev_r   <= out_ev_nxt;
    out_id_r   <= out_id_nxt;
    out_slot_r <= out_slot_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.event_res    = out_ev_r;
  assign out_ch.timer_id_res = out_id_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.last         = out_last_r;

  // A command or tick item always leaves idle on the next cycle.
  `ASSERT_NEXT(a_busy_after_item, clk, rst_n, in_ch.valid && in_ch.ready && (in_ch.op == ctt_pkg::OP_START || in_ch.op == ctt_pkg::OP_STOP || in_ch.op == ctt_pkg::OP_TICK), state_r != S_IDLE)
  // The ring is back in its home position whenever the controller is idle.
  `ASSERT_IMPLIES(a_ring_home, clk, rst_n, state_r == S_IDLE, cnt_r == '0)
  // No expiry is held back once an item is finished.
  `ASSERT_IMPLIES(a_no_pending_idle, clk, rst_n, state_r == S_IDLE, !pend_vld_r)
  // A result with the last flag is loaded only when leaving the finish state.
  `ASSERT_NEXT(a_last_from_finish, clk, rst_n, state_r != S_FINISH && state_r != S_TICK, !out_vld_r || !out_last_r || $stable(out_last_r) || $past(state_r) == S_FINISH)

endmodule

`default_nettype wire
